/* rtl/core/assert_macros.svh */
// Assertion macros shared by the collision resolve core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked check, off while reset is held
`define PCR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define PCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/pcr_pkg.sv */
// Shared widths, stage map, types and helpers of the collision resolve core
package pcr_pkg;
    localparam int FIELD_W    = 24;
    localparam int FRAC_BITS  = 8;
    localparam int U_FRAC     = 16;
    localparam int PUSH_SH    = U_FRAC - FRAC_BITS;
    localparam int PUSH_HALF  = (2 ** PUSH_SH) / 2;
    localparam int D_W        = FIELD_W + 1;
    localparam int SQ_W       = 2 * D_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int SQ_IN_W    = SUM_W + 1;
    localparam int ROOT_W     = SQ_IN_W / 2;
    localparam int Q_W        = U_FRAC + 1;
    localparam int U_W        = Q_W + 1;
    localparam int PR_W       = D_W + U_W;
    localparam int P_W        = PR_W + 1;
    localparam int PU_W       = P_W + U_W;
    localparam int RND_SH     = 2 * U_FRAC;
    localparam int DL_W       = PU_W - RND_SH + 1;
    localparam int SAT_W      = 32;

    localparam int SQ_STEPS   = ROOT_W;
    localparam int SQ_STAGES  = (SQ_STEPS + 1) / 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_STAGES = (DIV_STEPS + 1) / 2;

    localparam int ST_IN   = 0;
    localparam int ST_ABS  = 1;
    localparam int ST_NRM1 = 2;
    localparam int ST_NRM2 = 3;
    localparam int ST_SQR  = 4;
    localparam int ST_SUM  = 5;
    localparam int ST_SQ0  = 6;
    localparam int ST_SQL  = ST_SQ0 + SQ_STAGES - 1;
    localparam int ST_DV0  = ST_SQL + 1;
    localparam int ST_DVL  = ST_DV0 + DIV_STAGES - 1;
    localparam int ST_U    = ST_DVL + 1;
    localparam int ST_PRD  = ST_U + 1;
    localparam int ST_P    = ST_PRD + 1;
    localparam int ST_PU   = ST_P + 1;
    localparam int ST_RND  = ST_PU + 1;
    localparam int ST_OUT  = ST_RND + 1;
    localparam int NSTG    = ST_OUT + 1;

    typedef logic signed [FIELD_W-1:0] t_field;

    typedef struct packed {
        t_field                 a_pos_x;
        t_field                 a_pos_y;
        t_field                 a_vel_x;
        t_field                 a_vel_y;
        t_field                 b_pos_x;
        t_field                 b_pos_y;
        t_field                 b_vel_x;
        t_field                 b_vel_y;
        logic                   zero;
        logic                   sgn_x;
        logic                   sgn_y;
        logic [D_W-1:0]         nx;
        logic [D_W-1:0]         ny;
        logic signed [U_W-1:0]  ux;
        logic signed [U_W-1:0]  uy;
    } t_side;

    function automatic t_field sat_fld(logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'((2 ** (FIELD_W - 1)) - 1);
        lo = -SAT_W'(2 ** (FIELD_W - 1));
        if (v > hi) begin
            return t_field'(hi);
        end else if (v < lo) begin
            return t_field'(lo);
        end
        return v[FIELD_W-1:0];
    endfunction
endpackage

/* rtl/core/pair_collision_resolve_unit.sv */
// Equal-mass 2D collision resolve: one body pair in, new positions and velocities out.
// Input channel: i_valid with eight 24-bit signed fields; the block answers with o_stall.
// Output channel: o_valid with eight 24-bit signed fields; the receiver answers with i_stall.
// A beat moves on a channel at a clock edge where valid is high and stall is low.
// The block takes one pair per cycle while o_stall is low: every stage is a register with its own valid bit.
// Stages: offset, magnitude, two normalize steps, squares, sum, 13 square root stages
// (two root bits each), 9 divider stages (two quotient bits each, one in the last, x and y in parallel),
// sign, two projection stages, scaling product, rounding and the saturating output register.
// When the receiver stalls, the output holds and empty stages ahead of it keep filling;
// o_stall rises only once every stage holds a pair.
// Reset (synchronous, active low) drops all pairs in flight; no data is cleared.
// Coinciding positions give a zero unit vector, so each result equals its input.
module pair_collision_resolve_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [pcr_pkg::FIELD_W-1:0]   i_a_pos_x,
    input  logic signed [pcr_pkg::FIELD_W-1:0]   i_a_pos_y,
    input  logic signed [pcr_pkg::FIELD_W-1:0]   i_a_vel_x,
    input  logic signed [pcr_pkg::FIELD_W-1:0]   i_a_vel_y,
    input  logic signed [pcr_pkg::FIELD_W-1:0]   i_b_pos_x,
    input  logic signed [pcr_pkg::FIELD_W-1:0]   i_b_pos_y,
    input  logic signed [pcr_pkg::FIELD_W-1:0]   i_b_vel_x,
    input  logic signed [pcr_pkg::FIELD_W-1:0]   i_b_vel_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [pcr_pkg::FIELD_W-1:0]   o_new_a_pos_x,
    output logic signed [pcr_pkg::FIELD_W-1:0]   o_new_a_pos_y,
    output logic signed [pcr_pkg::FIELD_W-1:0]   o_new_a_vel_x,
    output logic signed [pcr_pkg::FIELD_W-1:0]   o_new_a_vel_y,
    output logic signed [pcr_pkg::FIELD_W-1:0]   o_new_b_pos_x,
    output logic signed [pcr_pkg::FIELD_W-1:0]   o_new_b_pos_y,
    output logic signed [pcr_pkg::FIELD_W-1:0]   o_new_b_vel_x,
    output logic signed [pcr_pkg::FIELD_W-1:0]   o_new_b_vel_y
);
    import pcr_pkg::*;
    `include "assert_macros.svh"

    typedef struct packed {
        logic [D_W-1:0] m;
        logic [D_W-1:0] mx;
        logic [D_W-1:0] my;
    } t_nrm;

    function automatic t_nrm nrm_step(t_nrm v, int amt);
        t_nrm r;
        r = v;
        if ((v.m >> (D_W - amt)) == '0) begin
            r.m  = v.m << amt;
            r.mx = v.mx << amt;
            r.my = v.my << amt;
        end
        return r;
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    t_side           r_side [NSTG];
    t_side           n_side [NSTG];

    logic signed [D_W-1:0]   r_dx, r_dy, n_dx, n_dy;
    t_nrm                    r_nrm1, r_nrm2, n_nrm1, n_nrm2, n_nrm3;
    logic [SQ_W-1:0]         r_sqx, r_sqy;
    logic [SUM_W-1:0]        r_sum;
    logic [ROOT_W-1:0]       w_root;
    logic [Q_W-1:0]          w_qx, w_qy;
    logic signed [D_W-1:0]   r_dvx, r_dvy;
    logic signed [PR_W-1:0]  r_prx, r_pry;
    logic signed [P_W-1:0]   r_p;
    logic signed [PU_W-1:0]  r_pux, r_puy;
    logic signed [DL_W-1:0]  r_dlx, r_dly, n_dlx, n_dly;
    logic signed [U_W-1:0]   r_px, r_py, n_px, n_py;
    t_field r_o_apx, r_o_apy, r_o_avx, r_o_avy, r_o_bpx, r_o_bpy, r_o_bvx, r_o_bvy;

    // a stage may load when it or any stage ahead of it is empty, or the output drains
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            en[k] = !i_stall || (|(~r_vld & ({NSTG{1'b1}} << k)));
        end
    end

    assign o_stall = !en[ST_IN];
    assign o_valid = r_vld[ST_OUT];

    always_comb begin
        n_dx = {i_b_pos_x[FIELD_W-1], i_b_pos_x} - {i_a_pos_x[FIELD_W-1], i_a_pos_x};
        n_dy = {i_b_pos_y[FIELD_W-1], i_b_pos_y} - {i_a_pos_y[FIELD_W-1], i_a_pos_y};
        for (int k = 0; k < NSTG; k++) begin
            if (k == ST_IN) begin
                n_side[k]         = r_side[k];
                n_side[k].a_pos_x = i_a_pos_x;
                n_side[k].a_pos_y = i_a_pos_y;
                n_side[k].a_vel_x = i_a_vel_x;
                n_side[k].a_vel_y = i_a_vel_y;
                n_side[k].b_pos_x = i_b_pos_x;
                n_side[k].b_pos_y = i_b_pos_y;
                n_side[k].b_vel_x = i_b_vel_x;
                n_side[k].b_vel_y = i_b_vel_y;
                n_side[k].zero    = (n_dx == '0) && (n_dy == '0);
                n_side[k].sgn_x   = n_dx[D_W-1];
                n_side[k].sgn_y   = n_dy[D_W-1];
            end else begin
                n_side[k] = r_side[k-1];
            end
            if (k == ST_NRM2) begin
                n_side[k].nx = n_nrm3.mx;
                n_side[k].ny = n_nrm3.my;
            end
            if (k == ST_U) begin
                if (r_side[k-1].zero) begin
                    n_side[k].ux = '0;
                    n_side[k].uy = '0;
                end else begin
                    n_side[k].ux = r_side[k-1].sgn_x ? -$signed({1'b0, w_qx})
                                                     : $signed({1'b0, w_qx});
                    n_side[k].uy = r_side[k-1].sgn_y ? -$signed({1'b0, w_qy})
                                                     : $signed({1'b0, w_qy});
                end
            end
        end
    end

    always_comb begin
        logic [PU_W-1:0]  mag_x, mag_y;
        logic [PU_W-1:0]  sum_x, sum_y;
        logic [U_W-1:0]   umag_x, umag_y;
        logic [U_W-1:0]   pmag_x, pmag_y;
        n_nrm1.mx = r_dx[D_W-1] ? D_W'(-r_dx) : D_W'(r_dx);
        n_nrm1.my = r_dy[D_W-1] ? D_W'(-r_dy) : D_W'(r_dy);
        n_nrm1.m  = (n_nrm1.mx > n_nrm1.my) ? n_nrm1.mx : n_nrm1.my;
        n_nrm2 = nrm_step(nrm_step(nrm_step(r_nrm1, 16), 8), 4);
        n_nrm3 = nrm_step(nrm_step(r_nrm2, 2), 1);

        // round the velocity change to nearest, ties away from zero
        mag_x = r_pux[PU_W-1] ? PU_W'(-r_pux) : PU_W'(r_pux);
        mag_y = r_puy[PU_W-1] ? PU_W'(-r_puy) : PU_W'(r_puy);
        sum_x = mag_x + (PU_W'(1) << (RND_SH - 1));
        sum_y = mag_y + (PU_W'(1) << (RND_SH - 1));
        n_dlx = r_pux[PU_W-1] ? -$signed({1'b0, sum_x[PU_W-1:RND_SH]})
                              : $signed({1'b0, sum_x[PU_W-1:RND_SH]});
        n_dly = r_puy[PU_W-1] ? -$signed({1'b0, sum_y[PU_W-1:RND_SH]})
                              : $signed({1'b0, sum_y[PU_W-1:RND_SH]});

        umag_x = r_side[ST_PU].ux[U_W-1] ? U_W'(-r_side[ST_PU].ux) : U_W'(r_side[ST_PU].ux);
        umag_y = r_side[ST_PU].uy[U_W-1] ? U_W'(-r_side[ST_PU].uy) : U_W'(r_side[ST_PU].uy);
        pmag_x = (umag_x + U_W'(PUSH_HALF)) >> PUSH_SH;
        pmag_y = (umag_y + U_W'(PUSH_HALF)) >> PUSH_SH;
        n_px = r_side[ST_PU].ux[U_W-1] ? -$signed(pmag_x) : $signed(pmag_x);
        n_py = r_side[ST_PU].uy[U_W-1] ? -$signed(pmag_y) : $signed(pmag_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == ST_IN) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
                r_side[k] <= n_side[k];
            end
        end
        if (en[ST_IN]) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (en[ST_ABS]) begin
            r_nrm1 <= n_nrm1;
        end
        if (en[ST_NRM1]) begin
            r_nrm2 <= n_nrm2;
        end
        if (en[ST_SQR]) begin
            r_sqx <= SQ_W'(r_side[ST_NRM2].nx) * SQ_W'(r_side[ST_NRM2].nx);
            r_sqy <= SQ_W'(r_side[ST_NRM2].ny) * SQ_W'(r_side[ST_NRM2].ny);
        end
        if (en[ST_SUM]) begin
            r_sum <= SUM_W'(r_sqx) + SUM_W'(r_sqy);
        end
        if (en[ST_U]) begin
            r_dvx <= D_W'(r_side[ST_DVL].b_vel_x) - D_W'(r_side[ST_DVL].a_vel_x);
            r_dvy <= D_W'(r_side[ST_DVL].b_vel_y) - D_W'(r_side[ST_DVL].a_vel_y);
        end
        if (en[ST_PRD]) begin
            r_prx <= PR_W'(r_dvx) * PR_W'(r_side[ST_U].ux);
            r_pry <= PR_W'(r_dvy) * PR_W'(r_side[ST_U].uy);
        end
        if (en[ST_P]) begin
            r_p <= P_W'(r_prx) + P_W'(r_pry);
        end
        if (en[ST_PU]) begin
            r_pux <= PU_W'(r_p) * PU_W'(r_side[ST_P].ux);
            r_puy <= PU_W'(r_p) * PU_W'(r_side[ST_P].uy);
        end
        if (en[ST_RND]) begin
            r_dlx <= n_dlx;
            r_dly <= n_dly;
            r_px  <= n_px;
            r_py  <= n_py;
        end
        if (en[ST_OUT]) begin
            r_o_apx <= sat_fld(SAT_W'(r_side[ST_RND].a_pos_x) - SAT_W'(r_px));
            r_o_apy <= sat_fld(SAT_W'(r_side[ST_RND].a_pos_y) - SAT_W'(r_py));
            r_o_avx <= sat_fld(SAT_W'(r_side[ST_RND].a_vel_x) + SAT_W'(r_dlx));
            r_o_avy <= sat_fld(SAT_W'(r_side[ST_RND].a_vel_y) + SAT_W'(r_dly));
            r_o_bpx <= sat_fld(SAT_W'(r_side[ST_RND].b_pos_x) + SAT_W'(r_px));
            r_o_bpy <= sat_fld(SAT_W'(r_side[ST_RND].b_pos_y) + SAT_W'(r_py));
            r_o_bvx <= sat_fld(SAT_W'(r_side[ST_RND].b_vel_x) - SAT_W'(r_dlx));
            r_o_bvy <= sat_fld(SAT_W'(r_side[ST_RND].b_vel_y) - SAT_W'(r_dly));
        end
    end

    pcr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en[ST_SQ0 +: SQ_STAGES]),
        .i_rad  ({1'b0, r_sum}),
        .o_root (w_root)
    );

    pcr_udiv u_div_x (
        .i_clk (i_clk),
        .i_en  (en[ST_DV0 +: DIV_STAGES]),
        .i_num (r_side[ST_SQL].nx),
        .i_den (w_root),
        .o_quo (w_qx)
    );

    pcr_udiv u_div_y (
        .i_clk (i_clk),
        .i_en  (en[ST_DV0 +: DIV_STAGES]),
        .i_num (r_side[ST_SQL].ny),
        .i_den (w_root),
        .o_quo (w_qy)
    );

    assign o_new_a_pos_x = r_o_apx;
    assign o_new_a_pos_y = r_o_apy;
    assign o_new_a_vel_x = r_o_avx;
    assign o_new_a_vel_y = r_o_avy;
    assign o_new_b_pos_x = r_o_bpx;
    assign o_new_b_pos_y = r_o_bpy;
    assign o_new_b_vel_x = r_o_bvx;
    assign o_new_b_vel_y = r_o_bvy;

    // input backs up only when every stage is occupied
    `PCR_ASSERT_ALWAYS(a_stall_full, i_clk, o_stall |-> (&r_vld), "input stalled with a free stage")
    // normalized offset keeps the root at or above 2^24
    `PCR_ASSERT(a_root_range, i_clk, i_rst_n, (r_vld[ST_SQL] && !r_side[ST_SQL].zero) |-> (w_root[ROOT_W-1] || w_root[ROOT_W-2]), "square root below normalized range")
    // a unit vector has one component of at least one half
    `PCR_ASSERT(a_unit_len, i_clk, i_rst_n, (r_vld[ST_DVL] && !r_side[ST_DVL].zero) |-> (w_qx[Q_W-1] || w_qx[Q_W-2] || w_qy[Q_W-1] || w_qy[Q_W-2]), "unit vector too short")
endmodule

/* rtl/core/pcr_isqrt.sv */
// Pipelined integer square root, two result bits per stage
module pcr_isqrt (
    input  logic                           i_clk,
    input  logic [pcr_pkg::SQ_STAGES-1:0]  i_en,
    input  logic [pcr_pkg::SQ_IN_W-1:0]    i_rad,
    output logic [pcr_pkg::ROOT_W-1:0]     o_root
);
    import pcr_pkg::*;

    localparam int REM_W = ROOT_W + 4;

    logic [REM_W-1:0]   r_rem  [SQ_STAGES];
    logic [ROOT_W-1:0]  r_root [SQ_STAGES];
    logic [SQ_IN_W-1:0] r_rad  [SQ_STAGES];
    logic [REM_W-1:0]   n_rem  [SQ_STAGES];
    logic [ROOT_W-1:0]  n_root [SQ_STAGES];
    logic [SQ_IN_W-1:0] n_rad  [SQ_STAGES];

    always_comb begin
        logic [REM_W-1:0]   rem;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        logic [ROOT_W-1:0]  root;
        logic [SQ_IN_W-1:0] rad;
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (s == 0) begin
                rem  = '0;
                root = '0;
                rad  = i_rad;
            end else begin
                rem  = r_rem[s-1];
                root = r_root[s-1];
                rad  = r_rad[s-1];
            end
            for (int j = 0; j < 2; j++) begin
                rem_sh = {rem[REM_W-3:0], rad[SQ_IN_W-1 -: 2]};
                trial  = {{(REM_W-ROOT_W-2){1'b0}}, root, 2'b01};
                if (rem_sh >= trial) begin
                    rem  = rem_sh - trial;
                    root = {root[ROOT_W-2:0], 1'b1};
                end else begin
                    rem  = rem_sh;
                    root = {root[ROOT_W-2:0], 1'b0};
                end
                rad = rad << 2;
            end
            n_rem[s]  = rem;
            n_root[s] = root;
            n_rad[s]  = rad;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_rad[s]  <= n_rad[s];
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1];
endmodule

/* rtl/core/pcr_udiv.sv */
// Pipelined restoring divider: (num << U_FRAC) / den, two quotient bits per stage, one in the last
module pcr_udiv (
    input  logic                            i_clk,
    input  logic [pcr_pkg::DIV_STAGES-1:0]  i_en,
    input  logic [pcr_pkg::D_W-1:0]         i_num,
    input  logic [pcr_pkg::ROOT_W-1:0]      i_den,
    output logic [pcr_pkg::Q_W-1:0]         o_quo
);
    import pcr_pkg::*;

    localparam int REM_W = ROOT_W + 1;

    logic [REM_W-1:0]  r_rem [DIV_STAGES];
    logic [Q_W-1:0]    r_quo [DIV_STAGES];
    logic [ROOT_W-1:0] r_den [DIV_STAGES];
    logic              r_lsb [DIV_STAGES];
    logic [REM_W-1:0]  n_rem [DIV_STAGES];
    logic [Q_W-1:0]    n_quo [DIV_STAGES];

    always_comb begin
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  rem_sh;
        logic [Q_W-1:0]    quo;
        logic [ROOT_W-1:0] den;
        logic              lsb;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                rem = REM_W'(i_num >> 1);
                quo = '0;
                den = i_den;
                lsb = i_num[0];
            end else begin
                rem = r_rem[s-1];
                quo = r_quo[s-1];
                den = r_den[s-1];
                lsb = r_lsb[s-1];
            end
            for (int j = 0; j < 2; j++) begin
                if (2 * s + j < DIV_STEPS) begin
                    // only the first step pulls in a live numerator bit
                    rem_sh = {rem[REM_W-2:0], (2 * s + j == 0) ? lsb : 1'b0};
                    if (rem_sh >= {1'b0, den}) begin
                        rem = rem_sh - {1'b0, den};
                        quo = {quo[Q_W-2:0], 1'b1};
                    end else begin
                        rem = rem_sh;
                        quo = {quo[Q_W-2:0], 1'b0};
                    end
                end
            end
            n_rem[s] = rem;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_den[s] <= (s == 0) ? i_den : r_den[s-1];
                r_lsb[s] <= (s == 0) ? i_num[0] : r_lsb[s-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];
endmodule
